### hw/rtl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int MAX_FRAME_BYTES = 512;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int HEADER_BYTES    = 8;
    localparam int IDX_W           = 9;
    localparam int POS_W           = 17;

    localparam logic [7:0]  START_BYTE = 8'h68;
    localparam logic [7:0]  TAIL_BYTE  = 8'h10;
    localparam logic [15:0] ALL_ONES   = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_END_GOOD = 2'd1,
        KIND_END_BAD  = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             result_kind;
        logic [7:0]        payload_byte;
        logic [IDX_W-1:0]  payload_index;
        logic [7:0]        command;
        logic [7:0]        read_write;
        logic [7:0]        status_reply;
        logic [15:0]       received_checksum;
        logic [IDX_W-1:0]  payload_length;
        logic              checksum_ok;
    } t_result;

    // inverted ones-complement sum of the two header words
    function automatic logic [15:0] header_checksum(
        input logic [7:0] command,
        input logic [7:0] read_write,
        input logic [7:0] status
    );
        logic [16:0] sum;
        logic [15:0] folded;
        sum    = {1'b0, START_BYTE, command} + {1'b0, read_write, status};
        folded = sum[15:0] + {15'd0, sum[16]};
        return folded ^ ALL_ONES;
    endfunction

endpackage

### hw/rtl/sfr_deframer.sv
`timescale 1ns / 1ps

module sfr_deframer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_chk_en,
    output logic              o_res_valid,
    output sfr_pkg::t_result  o_res
);

    logic [sfr_pkg::CNT_W-1:0] r_byte_count;
    logic [sfr_pkg::CNT_W-1:0] n_byte_count;
    logic [7:0]                r_command;
    logic [7:0]                r_read_write;
    logic [7:0]                r_status;
    logic [15:0]               r_checksum;
    logic [15:0]               r_length;

    logic [sfr_pkg::CNT_W-1:0] count_inc;
    logic [sfr_pkg::POS_W-1:0] end_pos;
    logic [sfr_pkg::CNT_W-1:0] index_full;
    logic                      in_body;
    logic                      at_end;
    logic                      at_limit;
    logic                      chk_ok;
    sfr_pkg::t_result          hdr;

    assign count_inc  = r_byte_count + 1'b1;
    assign end_pos    = sfr_pkg::POS_W'(sfr_pkg::HEADER_BYTES + 1) + {1'b0, r_length};
    assign index_full = count_inc - sfr_pkg::CNT_W'(sfr_pkg::HEADER_BYTES + 1);
    assign in_body    = r_byte_count >= sfr_pkg::CNT_W'(sfr_pkg::HEADER_BYTES);
    assign at_end     = {{(sfr_pkg::POS_W - sfr_pkg::CNT_W){1'b0}}, count_inc} == end_pos;
    assign at_limit   = count_inc >= sfr_pkg::CNT_W'(sfr_pkg::MAX_FRAME_BYTES);
    assign chk_ok     = !i_chk_en ||
                        (sfr_pkg::header_checksum(r_command, r_read_write, r_status)
                         == r_checksum);

    always_comb begin
        hdr                   = '0;
        hdr.command           = r_command;
        hdr.read_write        = r_read_write;
        hdr.status_reply      = r_status;
        hdr.received_checksum = r_checksum;
        hdr.payload_length    = r_length[sfr_pkg::IDX_W-1:0];
        hdr.checksum_ok       = chk_ok;
    end

    always_comb begin
        o_res_valid  = 1'b0;
        o_res        = '0;
        n_byte_count = r_byte_count;
        if (r_byte_count == '0) begin
            if (i_rx_byte == sfr_pkg::START_BYTE) begin
                n_byte_count = sfr_pkg::CNT_W'(1);
            end
        end else if (!in_body) begin
            n_byte_count = count_inc;
        end else if (at_end) begin
            o_res_valid       = 1'b1;
            o_res             = hdr;
            o_res.result_kind = (i_rx_byte == sfr_pkg::TAIL_BYTE) ?
                                sfr_pkg::KIND_END_GOOD : sfr_pkg::KIND_END_BAD;
            n_byte_count      = '0;
        end else if (at_limit) begin
            o_res_valid       = 1'b1;
            o_res             = hdr;
            o_res.result_kind = sfr_pkg::KIND_OVERFLOW;
            n_byte_count      = '0;
        end else begin
            o_res_valid         = 1'b1;
            o_res.result_kind   = sfr_pkg::KIND_PAYLOAD;
            o_res.payload_byte  = i_rx_byte;
            o_res.payload_index = index_full[sfr_pkg::IDX_W-1:0];
            n_byte_count        = count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_command    <= '0;
            r_read_write <= '0;
            r_status     <= '0;
            r_checksum   <= '0;
            r_length     <= '0;
        end else if (i_accept) begin
            r_byte_count <= n_byte_count;
            if (r_byte_count != '0 && !in_body) begin
                unique case (r_byte_count)
                    sfr_pkg::CNT_W'(1): r_command    <= i_rx_byte;
                    sfr_pkg::CNT_W'(2): r_read_write <= i_rx_byte;
                    sfr_pkg::CNT_W'(3): r_status     <= i_rx_byte;
                    sfr_pkg::CNT_W'(4): r_checksum   <= {i_rx_byte, 8'd0};
                    sfr_pkg::CNT_W'(5): r_checksum   <= {r_checksum[15:8], i_rx_byte};
                    sfr_pkg::CNT_W'(6): r_length     <= {i_rx_byte, 8'd0};
                    sfr_pkg::CNT_W'(7): r_length     <= {r_length[15:8], i_rx_byte};
                    default: ;
                endcase
            end
        end
    end

endmodule

### hw/rtl/sfr_out_reg.sv
`timescale 1ns / 1ps

module sfr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_load_valid,
    input  sfr_pkg::t_result  i_data,
    input  logic              i_stall,
    output logic              o_busy,
    output logic              o_valid,
    output sfr_pkg::t_result  o_data
);

    logic             r_valid;
    sfr_pkg::t_result r_data;

    // full and held by downstream
    assign o_busy  = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_busy) begin
            r_valid <= i_load && i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_busy && i_load && i_load_valid) begin
            r_data <= i_data;
        end
    end

endmodule

### hw/rtl/serial_frame_receiver_top.sv
`timescale 1ns / 1ps

// serial frame receiver: finds 0x68-headed, length-prefixed frames in a byte stream
// rx channel: i_rx_valid / o_rx_stall carry one received byte per transaction
// result channel: o_res_valid / i_res_stall carry one result per transaction,
//   either a payload byte with its index, a frame end (good or bad tail) with the
//   header fields and checksum flag, or an overflow abort with the header fields
// header bytes and bytes outside a frame produce no result
// cfg channel: i_cfg_valid / o_cfg_ready writes checksum_check_enable, always ready;
//   write it only while no frame byte is in flight
// output: a result is registered and presented in the cycle after the byte that caused it is taken
// throughput: one byte per cycle while the receiver takes every result
// receiver stall: while the output register holds a result and i_res_stall is high,
//   o_rx_stall is raised and the held result stays unchanged
// reset (synchronous, active low): hunts for a start byte, output empty,
//   checksum checking enabled
module serial_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [8:0]  o_payload_index,
    output logic [7:0]  o_command,
    output logic [7:0]  o_read_write,
    output logic [7:0]  o_status_reply,
    output logic [15:0] o_received_checksum,
    output logic [8:0]  o_payload_length,
    output logic        o_checksum_ok
);

    logic             r_chk_en;
    logic             rx_accept;
    logic             busy;
    logic             df_valid;
    sfr_pkg::t_result df_res;
    sfr_pkg::t_result out_res;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = busy;
    assign rx_accept   = i_rx_valid && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_chk_en <= i_cfg_data;
        end
    end

    sfr_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (rx_accept),
        .i_rx_byte   (i_rx_byte),
        .i_chk_en    (r_chk_en),
        .o_res_valid (df_valid),
        .o_res       (df_res)
    );

    sfr_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (rx_accept),
        .i_load_valid (df_valid),
        .i_data       (df_res),
        .i_stall      (i_res_stall),
        .o_busy       (busy),
        .o_valid      (o_res_valid),
        .o_data       (out_res)
    );

    assign o_result_kind       = out_res.result_kind;
    assign o_payload_byte      = out_res.payload_byte;
    assign o_payload_index     = out_res.payload_index;
    assign o_command           = out_res.command;
    assign o_read_write        = out_res.read_write;
    assign o_status_reply      = out_res.status_reply;
    assign o_received_checksum = out_res.received_checksum;
    assign o_payload_length    = out_res.payload_length;
    assign o_checksum_ok       = out_res.checksum_ok;

endmodule
